@@ rtl/stl_pkg.sv @@
// ============================================================================
// stl_pkg
// Shared types, token codes and character tables for the signature lexer.
// ============================================================================
`default_nettype none

package stl_pkg;

  // Input item: one code unit of the text and its end-of-text mark.
  typedef struct packed {
    logic [15:0] code_unit;
    logic        is_last;
  } stl_in_t;

  // Result item: one token.
  typedef struct packed {
    logic [4:0]  token_kind;
    logic [30:0] number_value;
    logic [15:0] ident_start;
    logic [15:0] ident_length;
    logic [1:0]  error_code;
    logic [15:0] error_char;
    logic        run_last;
  } stl_out_t;

  // Token kinds.
  localparam logic [4:0] KIND_END      = 5'd0;
  localparam logic [4:0] KIND_LBRACKET = 5'd1;
  localparam logic [4:0] KIND_RBRACKET = 5'd2;
  localparam logic [4:0] KIND_LPAREN   = 5'd3;
  localparam logic [4:0] KIND_RPAREN   = 5'd4;
  localparam logic [4:0] KIND_DCOLON   = 5'd5;
  localparam logic [4:0] KIND_BANG     = 5'd6;
  localparam logic [4:0] KIND_DBANG    = 5'd7;
  localparam logic [4:0] KIND_DOT      = 5'd8;
  localparam logic [4:0] KIND_LT       = 5'd9;
  localparam logic [4:0] KIND_GT       = 5'd10;
  localparam logic [4:0] KIND_COMMA    = 5'd11;
  localparam logic [4:0] KIND_BACKTICK = 5'd12;
  localparam logic [4:0] KIND_SLASH    = 5'd13;
  localparam logic [4:0] KIND_AMP      = 5'd14;
  localparam logic [4:0] KIND_KW_FIRST = 5'd15;
  localparam logic [4:0] KIND_IDENT    = 5'd24;
  localparam logic [4:0] KIND_NUMBER   = 5'd25;
  localparam logic [4:0] KIND_ERROR    = 5'd26;

  // Error codes.
  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_END_COLON  = 2'd1;
  localparam logic [1:0] ERR_BAD_COLON  = 2'd2;
  localparam logic [1:0] ERR_UNHANDLED  = 2'd3;

  // Characters that the lexer tests for.
  localparam logic [15:0] CH_TAB      = 16'h0009;
  localparam logic [15:0] CH_LF       = 16'h000A;
  localparam logic [15:0] CH_CR       = 16'h000D;
  localparam logic [15:0] CH_SPACE    = 16'h0020;
  localparam logic [15:0] CH_BANG     = 16'h0021;
  localparam logic [15:0] CH_AMP      = 16'h0026;
  localparam logic [15:0] CH_LPAREN   = 16'h0028;
  localparam logic [15:0] CH_RPAREN   = 16'h0029;
  localparam logic [15:0] CH_COMMA    = 16'h002C;
  localparam logic [15:0] CH_DOT      = 16'h002E;
  localparam logic [15:0] CH_SLASH    = 16'h002F;
  localparam logic [15:0] CH_ZERO     = 16'h0030;
  localparam logic [15:0] CH_NINE     = 16'h0039;
  localparam logic [15:0] CH_COLON    = 16'h003A;
  localparam logic [15:0] CH_LT       = 16'h003C;
  localparam logic [15:0] CH_GT       = 16'h003E;
  localparam logic [15:0] CH_UPPER_A  = 16'h0041;
  localparam logic [15:0] CH_UPPER_Z  = 16'h005A;
  localparam logic [15:0] CH_LBRACKET = 16'h005B;
  localparam logic [15:0] CH_RBRACKET = 16'h005D;
  localparam logic [15:0] CH_USCORE   = 16'h005F;
  localparam logic [15:0] CH_BACKTICK = 16'h0060;
  localparam logic [15:0] CH_LOWER_A  = 16'h0061;
  localparam logic [15:0] CH_LOWER_Z  = 16'h007A;

  localparam int          KW_COUNT  = 9;
  localparam logic [8:0]  KW_ALL    = 9'h1FF;
  localparam logic [30:0] NUM_MAX   = 31'h7FFF_FFFF;

  // Result queue depth; one character yields at most three tokens.
  localparam int QUEUE_DEPTH = 4;
  localparam int MAX_TOKENS  = 3;

  // Keyword text, left aligned, zero padded to nine characters.
  function automatic logic [71:0] kw_text(input logic [3:0] k);
    logic [71:0] t;
    case (k)
      4'd0:    t = {"instance", 8'h00};
      4'd1:    t = {"class", 32'h0};
      4'd2:    t = "valuetype";
      4'd3:    t = {"object", 24'h0};
      4'd4:    t = {"void", 40'h0};
      4'd5:    t = {"bool", 40'h0};
      4'd6:    t = {"string", 24'h0};
      4'd7:    t = {"uint32", 24'h0};
      4'd8:    t = {"int32", 32'h0};
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [3:0] kw_len(input logic [3:0] k);
    logic [3:0] l;
    case (k)
      4'd0:    l = 4'd8;
      4'd1:    l = 4'd5;
      4'd2:    l = 4'd9;
      4'd3:    l = 4'd6;
      4'd4:    l = 4'd4;
      4'd5:    l = 4'd4;
      4'd6:    l = 4'd6;
      4'd7:    l = 4'd6;
      4'd8:    l = 4'd5;
      default: l = 4'd0;
    endcase
    return l;
  endfunction

  // Character of keyword k at index idx (idx below nine).
  function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [3:0] idx);
    logic [71:0] t;
    logic [7:0]  ch;
    t  = kw_text(k);
    ch = 8'h00;
    case (idx)
      4'd0:    ch = t[71:64];
      4'd1:    ch = t[63:56];
      4'd2:    ch = t[55:48];
      4'd3:    ch = t[47:40];
      4'd4:    ch = t[39:32];
      4'd5:    ch = t[31:24];
      4'd6:    ch = t[23:16];
      4'd7:    ch = t[15:8];
      4'd8:    ch = t[7:0];
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic is_alpha(input logic [15:0] c);
    return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
           ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z));
  endfunction

  function automatic logic is_digit(input logic [15:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_space(input logic [15:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  // Single-character punctuation; KIND_END means the character is not one.
  function automatic logic [4:0] punct_kind(input logic [15:0] c);
    logic [4:0] k;
    case (c)
      CH_LBRACKET: k = KIND_LBRACKET;
      CH_RBRACKET: k = KIND_RBRACKET;
      CH_LPAREN:   k = KIND_LPAREN;
      CH_RPAREN:   k = KIND_RPAREN;
      CH_DOT:      k = KIND_DOT;
      CH_LT:       k = KIND_LT;
      CH_GT:       k = KIND_GT;
      CH_COMMA:    k = KIND_COMMA;
      CH_BACKTICK: k = KIND_BACKTICK;
      CH_SLASH:    k = KIND_SLASH;
      CH_AMP:      k = KIND_AMP;
      default:     k = KIND_END;
    endcase
    return k;
  endfunction

  function automatic stl_out_t make_tok(
    input logic [4:0]  kind,
    input logic [30:0] num,
    input logic [15:0] start,
    input logic [15:0] len,
    input logic [1:0]  ecode,
    input logic [15:0] echar
  );
    stl_out_t t;
    t.token_kind   = kind;
    t.number_value = num;
    t.ident_start  = start;
    t.ident_length = len;
    t.error_code   = ecode;
    t.error_char   = echar;
    t.run_last     = 1'b0;
    return t;
  endfunction

endpackage

`default_nettype wire

@@ rtl/signature_token_lexer_unit.sv @@
// ============================================================================
// signature_token_lexer_unit
// Character-at-a-time lexer for type-signature text, one code unit per transfer.
// ============================================================================
// The block takes one character per cycle while in_stall is low. An accepted
// character sits in an input register until the result queue has room for a
// full burst, then the lexer state and the zero to three tokens that the
// character causes are produced in a single pass and written into a
// four-entry result queue. With an empty queue the character is held in the
// input register and its first token in a queue entry register, from which
// it is offered on the output. Tokens leave one per transfer. Characters that
// cause at most one token each follow back to back as long as the output is
// not stalled; a character that causes more than one token stalls the input
// while the queue drains, and a stalled output fills the queue until the
// input stalls as well. The input stalls only while the queue has fewer than
// three free entries, which is the worst burst a single character can cause
// (a pending token, a punctuation or new token, and the end token). An error
// token ends a text: everything up to and including the last-marked
// character is then dropped without results. After every last-marked
// character the lexer returns to its reset state and offsets restart at zero.
`default_nettype none

module signature_token_lexer_unit #(
  parameter int POSITION_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire stl_pkg::stl_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output stl_pkg::stl_out_t      out_data
);
  import stl_pkg::*;

  localparam int P_W   = POSITION_BITS;
  localparam int EXT_W = (P_W > 16) ? P_W : 16;

  // Lexer modes, one-hot.
  typedef enum logic [5:0] {
    MODE_IDLE  = 6'b000001,
    MODE_IDENT = 6'b000010,
    MODE_NUM   = 6'b000100,
    MODE_COLON = 6'b001000,
    MODE_BANG  = 6'b010000,
    MODE_ERR   = 6'b100000
  } mode_t;

  // Input register.
  logic        st_vld_r;
  stl_in_t     st_data_r;

  // Lexer state.
  mode_t        mode_r, mode_nxt;
  logic [P_W-1:0] pos_r, pos_nxt;
  logic [P_W-1:0] start_r, start_nxt;
  logic [8:0]   flags_r, flags_nxt;
  logic [30:0]  acc_r, acc_nxt;

  // Tokens of the character in the input register.
  stl_out_t [2:0] tok;
  logic [1:0]     tok_cnt;
  logic           room;
  logic           fwd;

  // Offsets are reported on 16 bits whatever the position width.
  function automatic logic [15:0] to16(input logic [P_W-1:0] x);
    logic [EXT_W-1:0] e;
    e = EXT_W'(x);
    return e[15:0];
  endfunction

  // Keyword kind for a finished identifier, or the plain identifier kind.
  function automatic logic [4:0] ident_kind(input logic [8:0] flags,
                                            input logic [P_W-1:0] len);
    logic [4:0] kind;
    kind = KIND_IDENT;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (flags[k] && (len == P_W'(kw_len(4'(k))))) begin
        kind = KIND_KW_FIRST + 5'(k);
      end
    end
    return kind;
  endfunction

  // Drop keywords that do not have character c at index idx.
  function automatic logic [8:0] match_char(input logic [8:0] flags,
                                            input logic [15:0] c,
                                            input logic [P_W-1:0] idx);
    logic [8:0] f;
    logic       hit;
    f = flags;
    for (int k = 0; k < KW_COUNT; k++) begin
      hit = (idx < P_W'(kw_len(4'(k)))) &&
            (c == {8'h00, kw_char(4'(k), idx[3:0])});
      if (!hit) begin
        f[k] = 1'b0;
      end
    end
    return f;
  endfunction

  // The input register advances when the queue can take a full burst.
  assign fwd      = st_vld_r && room;
  assign in_stall = st_vld_r && !room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_vld_r <= 1'b0;
    end else if (!in_stall) begin
      st_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      st_data_r <= in_data;
    end
  end

  // One character through the lexer: state update and its tokens.
  always_comb begin
    logic [15:0]    c;
    logic           last;
    logic           done;
    logic [1:0]     n;
    logic [4:0]     pk;
    logic [34:0]    prod;
    logic [P_W-1:0] len;

    c    = st_data_r.code_unit;
    last = st_data_r.is_last;
    done = 1'b0;
    n    = 2'd0;
    pk   = KIND_END;
    prod = '0;
    len  = '0;
    tok  = '0;

    mode_nxt  = mode_r;
    pos_nxt   = pos_r;
    start_nxt = start_r;
    flags_nxt = flags_r;
    acc_nxt   = acc_r;

    if (mode_r == MODE_ERR) begin
      // Discard until the end of the text.
      if (last) begin
        mode_nxt  = MODE_IDLE;
        pos_nxt   = '0;
        start_nxt = '0;
        flags_nxt = KW_ALL;
        acc_nxt   = '0;
      end
    end else begin
      // Finish or continue what the previous character started.
      case (mode_r)
        MODE_COLON: begin
          if (c == CH_COLON) begin
            tok[n] = make_tok(KIND_DCOLON, '0, '0, '0, ERR_NONE, '0);
            mode_nxt = MODE_IDLE;
          end else begin
            tok[n] = make_tok(KIND_ERROR, '0, '0, '0, ERR_BAD_COLON, c);
            mode_nxt = MODE_ERR;
          end
          n    = n + 2'd1;
          done = 1'b1;
        end
        MODE_BANG: begin
          mode_nxt = MODE_IDLE;
          if (c == CH_BANG) begin
            tok[n] = make_tok(KIND_DBANG, '0, '0, '0, ERR_NONE, '0);
            done   = 1'b1;
          end else begin
            tok[n] = make_tok(KIND_BANG, '0, '0, '0, ERR_NONE, '0);
          end
          n = n + 2'd1;
        end
        MODE_IDENT: begin
          if (is_alpha(c) || is_digit(c) || (c == CH_USCORE) || (c == CH_DOT)) begin
            flags_nxt = match_char(flags_r, c, pos_r - start_r);
            done      = 1'b1;
          end else begin
            len    = pos_r - start_r;
            tok[n] = make_tok(ident_kind(flags_r, len), '0, to16(start_r), to16(len),
                              ERR_NONE, '0);
            n        = n + 2'd1;
            mode_nxt = MODE_IDLE;
          end
        end
        MODE_NUM: begin
          if (is_digit(c)) begin
            prod = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {31'd0, c[3:0]};
            acc_nxt = (prod > {4'd0, NUM_MAX}) ? NUM_MAX : prod[30:0];
            done    = 1'b1;
          end else begin
            tok[n]   = make_tok(KIND_NUMBER, acc_r, '0, '0, ERR_NONE, '0);
            n        = n + 2'd1;
            mode_nxt = MODE_IDLE;
          end
        end
        default: begin
          mode_nxt = MODE_IDLE;
        end
      endcase

      // Start something new with this character.
      if (!done) begin
        pk = punct_kind(c);
        if (pk != KIND_END) begin
          tok[n] = make_tok(pk, '0, '0, '0, ERR_NONE, '0);
          n      = n + 2'd1;
        end else if (c == CH_COLON) begin
          mode_nxt = MODE_COLON;
        end else if (c == CH_BANG) begin
          mode_nxt = MODE_BANG;
        end else if (is_space(c)) begin
          // Whitespace separates tokens and is otherwise dropped.
        end else if (is_alpha(c) || (c == CH_USCORE)) begin
          mode_nxt  = MODE_IDENT;
          start_nxt = pos_r;
          flags_nxt = match_char(KW_ALL, c, '0);
        end else if (is_digit(c)) begin
          mode_nxt = MODE_NUM;
          acc_nxt  = {27'd0, c[3:0]};
        end else begin
          tok[n]   = make_tok(KIND_ERROR, '0, '0, '0, ERR_UNHANDLED, c);
          n        = n + 2'd1;
          mode_nxt = MODE_ERR;
        end
      end

      pos_nxt = pos_r + P_W'(1);

      // End of text: flush the open token, then the end token unless an
      // error closed the text.
      if (last) begin
        case (mode_nxt)
          MODE_IDENT: begin
            len    = pos_nxt - start_nxt;
            tok[n] = make_tok(ident_kind(flags_nxt, len), '0, to16(start_nxt),
                              to16(len), ERR_NONE, '0);
            n      = n + 2'd1;
          end
          MODE_NUM: begin
            tok[n] = make_tok(KIND_NUMBER, acc_nxt, '0, '0, ERR_NONE, '0);
            n      = n + 2'd1;
          end
          MODE_BANG: begin
            tok[n] = make_tok(KIND_BANG, '0, '0, '0, ERR_NONE, '0);
            n      = n + 2'd1;
          end
          MODE_COLON: begin
            tok[n]   = make_tok(KIND_ERROR, '0, '0, '0, ERR_END_COLON, '0);
            n        = n + 2'd1;
            mode_nxt = MODE_ERR;
          end
          default: begin
          end
        endcase
        if (mode_nxt != MODE_ERR) begin
          tok[n] = make_tok(KIND_END, '0, '0, '0, ERR_NONE, '0);
          n      = n + 2'd1;
        end
        mode_nxt  = MODE_IDLE;
        pos_nxt   = '0;
        start_nxt = '0;
        flags_nxt = KW_ALL;
        acc_nxt   = '0;
      end
    end

    // Mark the final token that this character caused.
    if (n != 2'd0) begin
      tok[n - 2'd1].run_last = 1'b1;
    end
    tok_cnt = fwd ? n : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      pos_r   <= '0;
      start_r <= '0;
      flags_r <= KW_ALL;
      acc_r   <= '0;
    end else if (fwd) begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      flags_r <= flags_nxt;
      acc_r   <= acc_nxt;
    end
  end

  stl_result_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (tok_cnt),
    .push_data (tok),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ rtl/stl_result_queue.sv @@
// ============================================================================
// stl_result_queue
// Small token queue: takes up to three tokens per cycle, gives one per transfer.
// ============================================================================
`default_nettype none

module stl_result_queue (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [1:0]                  push_cnt,
  input  wire stl_pkg::stl_out_t [2:0]     push_data,
  output logic                             room,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output stl_pkg::stl_out_t                out_data
);
  import stl_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  stl_out_t [QUEUE_DEPTH-1:0] entry_r, entry_nxt;
  logic [PTR_W-1:0]           head_r, head_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       pop;
  logic [PTR_W-1:0]           tail;

  assign out_valid = (cnt_r != '0);
  assign out_data  = entry_r[head_r];
  assign pop       = out_valid && !out_stall;
  // There must be space for the largest burst one character can cause.
  assign room      = (cnt_r <= CNT_W'(QUEUE_DEPTH - MAX_TOKENS));
  assign tail      = head_r + cnt_r[PTR_W-1:0];

  always_comb begin
    head_nxt = pop ? head_r + PTR_W'(1) : head_r;
    cnt_nxt  = cnt_r + CNT_W'(push_cnt) - CNT_W'(pop);
  end

  always_comb begin
    entry_nxt = entry_r;
    for (int i = 0; i < MAX_TOKENS; i++) begin
      if (2'(i) < push_cnt) begin
        entry_nxt[tail + PTR_W'(i)] = push_data[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire

@@ tb/tb_signature_token_lexer_unit.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb_signature_token_lexer_unit
// Self-checking testbench: a directed table of short texts walks through
// every error and several token kinds, then random texts built from identifiers,
// keywords, numbers, punctuation and noise run under varied back-pressure.
// Each accepted character is lexed again by a model inside the testbench,
// and every token the block hands out is compared field by field.
// ============================================================================
module tb_signature_token_lexer_unit;
  import stl_pkg::*;

  // Cycles without any transfer on either channel before the run is declared
  // hung. The worst honest gap is the long receiver hold-off plus a tail of
  // random stalls, both well below this.
  localparam int STALL_LIMIT = 4000;
  // Length of the forced receiver hold-off that fills the result queue.
  localparam int HOLD_CYCLES = 60;
  // Cycles allowed after the last expected token, to catch stray extras.
  localparam int DRAIN_TAIL  = 8;

  // --------------------------------------------------------------------------
  // Clock, reset and the block under test.
  // --------------------------------------------------------------------------
  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  stl_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  stl_out_t out_data;

  always #5 clk = ~clk;

  signature_token_lexer_unit #(
    .POSITION_BITS(16)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // --------------------------------------------------------------------------
  // Lexer model. It keeps its own copy of the scan state and, for every
  // accepted character, produces the tokens that character releases. Offsets
  // and lengths are 16-bit vectors so that position wrap falls out of the
  // arithmetic for free.
  // --------------------------------------------------------------------------
  typedef enum logic [5:0] {
    LEX_IDLE    = 6'b000001,
    LEX_IDENT   = 6'b000010,
    LEX_NUMBER  = 6'b000100,
    LEX_COLON   = 6'b001000,
    LEX_BANG    = 6'b010000,
    LEX_DISCARD = 6'b100000
  } lex_mode_t;

  lex_mode_t   lex_mode;
  logic [15:0] next_offset;
  logic [15:0] ident_begin;
  logic [8:0]  kw_alive;
  logic [30:0] number_sum;

  // Tokens released by the character being modeled, and the tokens still
  // owed by the block, oldest first.
  stl_out_t char_tokens[$];
  stl_out_t token_q[$];

  // Keyword spellings in token order: entry k is token kind KIND_KW_FIRST + k.
  string kw_word [KW_COUNT] = '{"instance", "class", "valuetype", "object",
                                "void", "bool", "string", "uint32", "int32"};

  task automatic clear_lexer();
    lex_mode    = LEX_IDLE;
    next_offset = '0;
    ident_begin = '0;
    kw_alive    = KW_ALL;
    number_sum  = '0;
  endtask

  task automatic add_token(input logic [4:0] kind, input logic [30:0] num,
                           input logic [15:0] start, input logic [15:0] len,
                           input logic [1:0] ecode, input logic [15:0] echar);
    stl_out_t t;
    t.token_kind   = kind;
    t.number_value = num;
    t.ident_start  = start;
    t.ident_length = len;
    t.error_code   = ecode;
    t.error_char   = echar;
    t.run_last     = 1'b0;
    char_tokens = {char_tokens, t};
  endtask

  function automatic logic is_letter(input logic [15:0] c);
    return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z);
  endfunction

  function automatic logic is_dec(input logic [15:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic [4:0] punct_of(input logic [15:0] c);
    case (c)
      CH_LBRACKET: return KIND_LBRACKET;
      CH_RBRACKET: return KIND_RBRACKET;
      CH_LPAREN:   return KIND_LPAREN;
      CH_RPAREN:   return KIND_RPAREN;
      CH_DOT:      return KIND_DOT;
      CH_LT:       return KIND_LT;
      CH_GT:       return KIND_GT;
      CH_COMMA:    return KIND_COMMA;
      CH_BACKTICK: return KIND_BACKTICK;
      CH_SLASH:    return KIND_SLASH;
      CH_AMP:      return KIND_AMP;
      default:     return KIND_END;
    endcase
  endfunction

  // Drop every keyword whose character at position idx differs from c, or
  // that is already shorter than idx + 1.
  task automatic narrow_keywords(input logic [15:0] c, input logic [15:0] idx);
    for (int k = 0; k < KW_COUNT; k++) begin
      if (idx >= 16'(kw_word[k].len()) || {8'h00, kw_word[k][idx]} != c)
        kw_alive[k] = 1'b0;
    end
  endtask

  // Close the running identifier at end_pos. The first keyword still alive
  // whose length matches turns it into a keyword token.
  task automatic close_ident(input logic [15:0] end_pos);
    logic [15:0] span;
    logic [4:0]  kind;
    span = end_pos - ident_begin;
    kind = KIND_IDENT;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (kw_alive[k] && span == 16'(kw_word[k].len()))
        kind = KIND_KW_FIRST + 5'(k);
    end
    add_token(kind, '0, ident_begin, span, ERR_NONE, '0);
  endtask

  task automatic lex_char(input stl_in_t item);
    logic [15:0] c;
    logic [15:0] pos;
    logic        consumed;
    logic [4:0]  pk;
    logic [63:0] grown;
    c        = item.code_unit;
    pos      = next_offset;
    consumed = 1'b0;
    char_tokens.delete();

    // After an error everything up to the end of the text is swallowed.
    if (lex_mode == LEX_DISCARD) begin
      if (item.is_last)
        clear_lexer();
      return;
    end

    // First let the pending token react to the new character. Some states
    // consume it; the others flush their token and fall through to a fresh
    // scan of the same character.
    case (lex_mode)
      LEX_COLON: begin
        if (c == CH_COLON) begin
          add_token(KIND_DCOLON, '0, '0, '0, ERR_NONE, '0);
          lex_mode = LEX_IDLE;
        end else begin
          add_token(KIND_ERROR, '0, '0, '0, ERR_BAD_COLON, c);
          lex_mode = LEX_DISCARD;
        end
        consumed = 1'b1;
      end
      LEX_BANG: begin
        lex_mode = LEX_IDLE;
        if (c == CH_BANG) begin
          add_token(KIND_DBANG, '0, '0, '0, ERR_NONE, '0);
          consumed = 1'b1;
        end else begin
          add_token(KIND_BANG, '0, '0, '0, ERR_NONE, '0);
        end
      end
      LEX_IDENT: begin
        if (is_letter(c) || is_dec(c) || c == CH_USCORE || c == CH_DOT) begin
          narrow_keywords(c, pos - ident_begin);
          consumed = 1'b1;
        end else begin
          close_ident(pos);
          lex_mode = LEX_IDLE;
        end
      end
      LEX_NUMBER: begin
        if (is_dec(c)) begin
          grown      = 64'(number_sum) * 64'd10 + 64'(c - CH_ZERO);
          number_sum = (grown > 64'(NUM_MAX)) ? NUM_MAX : grown[30:0];
          consumed   = 1'b1;
        end else begin
          add_token(KIND_NUMBER, number_sum, '0, '0, ERR_NONE, '0);
          lex_mode = LEX_IDLE;
        end
      end
      default: lex_mode = LEX_IDLE;
    endcase

    if (!consumed) begin
      pk = punct_of(c);
      if (pk != KIND_END) begin
        add_token(pk, '0, '0, '0, ERR_NONE, '0);
      end else if (c == CH_COLON) begin
        lex_mode = LEX_COLON;
      end else if (c == CH_BANG) begin
        lex_mode = LEX_BANG;
      end else if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) begin
        // Whitespace only separates tokens.
      end else if (is_letter(c) || c == CH_USCORE) begin
        lex_mode    = LEX_IDENT;
        ident_begin = pos;
        kw_alive    = KW_ALL;
        narrow_keywords(c, 16'd0);
      end else if (is_dec(c)) begin
        lex_mode   = LEX_NUMBER;
        number_sum = 31'(c - CH_ZERO);
      end else begin
        add_token(KIND_ERROR, '0, '0, '0, ERR_UNHANDLED, c);
        lex_mode = LEX_DISCARD;
      end
    end

    next_offset = pos + 16'd1;

    // The last-marked character flushes whatever is pending, adds the end
    // token unless the text died in an error, and rewinds to offset zero.
    if (item.is_last) begin
      case (lex_mode)
        LEX_IDENT:  close_ident(next_offset);
        LEX_NUMBER: add_token(KIND_NUMBER, number_sum, '0, '0, ERR_NONE, '0);
        LEX_BANG:   add_token(KIND_BANG, '0, '0, '0, ERR_NONE, '0);
        LEX_COLON: begin
          add_token(KIND_ERROR, '0, '0, '0, ERR_END_COLON, '0);
          lex_mode = LEX_DISCARD;
        end
        default: ;
      endcase
      if (lex_mode != LEX_DISCARD)
        add_token(KIND_END, '0, '0, '0, ERR_NONE, '0);
      clear_lexer();
    end

    if (char_tokens.size() > 0)
      char_tokens[char_tokens.size() - 1].run_last = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Sender. Inputs change only at rising edges, through nonblocking
  // assignments. A transfer is taken at the edge where in_valid is high and
  // in_stall low; the model is stepped right there, so the expectation is
  // queued before the block can answer.
  // --------------------------------------------------------------------------
  int   send_gap_pct;
  int   recv_stall_pct;
  logic hold_out = 1'b0;

  task automatic send_char(input stl_in_t item, input logic typed, input stl_out_t typed_tok);
    if ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_gap_pct);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    lex_char(item);
    // Directed rows with a hand-written answer stand in for the model output.
    if (typed)
      token_q = {token_q, typed_tok};
    else
      foreach (char_tokens[i]) token_q = {token_q, char_tokens[i]};
  endtask

  // Sender pauses until every token it is owed has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (token_q.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Random text construction. A text is a run of words; most are well-formed
  // (identifiers, keywords and near-keywords, numbers, punctuation, '::',
  // '!', '!!', whitespace) so the scanner reaches every state. Noisy texts
  // mix in arbitrary code units, a colon followed by a random character, and
  // may end on a lone colon.
  // --------------------------------------------------------------------------
  logic [15:0] text_units[$];

  logic [15:0] punct_units [11] = '{CH_LBRACKET, CH_RBRACKET, CH_LPAREN, CH_RPAREN,
                                    CH_DOT, CH_LT, CH_GT, CH_COMMA, CH_BACKTICK,
                                    CH_SLASH, CH_AMP};
  logic [15:0] blank_units [4]  = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};

  // Append one code unit to the text being built.
  task automatic add_unit(input logic [15:0] u);
    text_units = {text_units, u};
  endtask

  function automatic logic [15:0] ident_unit(input logic first);
    int r;
    r = $urandom_range(0, first ? 52 : 65);
    if (r < 26)
      return CH_LOWER_A + 16'(r);
    else if (r < 52)
      return CH_UPPER_A + 16'(r - 26);
    else if (r == 52)
      return CH_USCORE;
    else if (r < 63)
      return CH_ZERO + 16'(r - 53);
    else
      return CH_DOT;
  endfunction

  task automatic push_word(input logic noisy);
    int pick;
    int k;
    int n;
    int variant;
    pick = $urandom_range(0, 99);
    if (noisy && $urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 3))
        0: add_unit(16'($urandom));
        1: begin
          add_unit(CH_COLON);
          add_unit(16'($urandom_range(0, 127)));
        end
        2:       add_unit(16'($urandom_range(128, 65535)));
        default: add_unit(16'($urandom_range(0, 31)));
      endcase
    end else if (pick < 30) begin
      // Exact keyword, keyword cut short, keyword with a tail, or free name.
      k       = $urandom_range(0, KW_COUNT - 1);
      n       = kw_word[k].len();
      variant = $urandom_range(0, 3);
      if (variant == 3) begin
        add_unit(ident_unit(1'b1));
        repeat ($urandom_range(0, 11)) add_unit(ident_unit(1'b0));
      end else begin
        for (int i = 0; i < ((variant == 1) ? n - 1 : n); i++)
          add_unit(16'(kw_word[k][i]));
        if (variant == 2)
          add_unit(ident_unit(1'b0));
      end
      if ($urandom_range(0, 1))
        add_unit(CH_SPACE);
    end else if (pick < 45) begin
      // Mostly short numbers; some long enough to saturate.
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 5);
      repeat (n) add_unit(CH_ZERO + 16'($urandom_range(0, 9)));
    end else if (pick < 70) begin
      add_unit(punct_units[$urandom_range(0, 10)]);
    end else if (pick < 78) begin
      add_unit(CH_COLON);
      add_unit(CH_COLON);
    end else if (pick < 86) begin
      repeat ($urandom_range(1, 2)) add_unit(CH_BANG);
    end else begin
      repeat ($urandom_range(1, 3)) add_unit(blank_units[$urandom_range(0, 3)]);
    end
  endtask

  // Send the built text, marking its final character as last.
  task automatic send_units();
    stl_in_t item;
    for (int i = 0; i < text_units.size(); i++) begin
      item.code_unit = text_units[i];
      item.is_last   = (i == text_units.size() - 1);
      send_char(item, 1'b0, '0);
    end
    text_units.delete();
  endtask

  // Send random texts until about `quota` characters have gone in. With
  // with_hold set, the receiver is told to hold off once, a third of the way
  // in, while the texts keep coming.
  task automatic random_texts(input int quota, input logic with_hold);
    int   sent;
    int   words;
    logic noisy;
    logic held;
    sent = 0;
    held = 1'b0;
    while (sent < quota) begin
      noisy = ($urandom_range(0, 99) < 15);
      words = $urandom_range(1, 8);
      repeat (words) push_word(noisy);
      if (noisy && $urandom_range(0, 3) == 0)
        add_unit(CH_COLON);
      sent += text_units.size();
      if (with_hold && !held && sent > quota / 3) begin
        hold_out = 1'b1;
        held     = 1'b1;
      end
      send_units();
    end
  endtask

  // --------------------------------------------------------------------------
  // Directed table. Each row is one character; rows whose answer is obvious
  // (a double colon or bang, the single-token errors, a blank text's end token)
  // carry it by hand, the rest are answered by the model.
  // --------------------------------------------------------------------------
  typedef struct packed {
    stl_in_t  item;
    logic     typed;
    stl_out_t tok;
  } dir_row_t;

  localparam stl_out_t NO_TOKEN = '0;

  dir_row_t dir_rows [25] = '{
    // Keyword int32 closed by '<'; both tokens are caused by the '<' character.
    '{'{"i", 1'b0}, 1'b0, NO_TOKEN},
    '{'{"n", 1'b0}, 1'b0, NO_TOKEN},
    '{'{"t", 1'b0}, 1'b0, NO_TOKEN},
    '{'{"3", 1'b0}, 1'b0, NO_TOKEN},
    '{'{"2", 1'b0}, 1'b0, NO_TOKEN},
    '{'{"<", 1'b0}, 1'b0, NO_TOKEN},
    // Double colon and double bang.
    '{'{":", 1'b0}, 1'b0, NO_TOKEN},
    '{'{":", 1'b0}, 1'b1, '{KIND_DCOLON, 31'd0, 16'd0, 16'd0, ERR_NONE, 16'd0, 1'b1}},
    '{'{"!", 1'b0}, 1'b0, NO_TOKEN},
    '{'{"!", 1'b0}, 1'b1, '{KIND_DBANG, 31'd0, 16'd0, 16'd0, ERR_NONE, 16'd0, 1'b1}},
    // Single bang followed by a lone dot, then an identifier holding a dot
    // and a digit that runs into the end of the text.
    '{'{"!", 1'b0}, 1'b0, NO_TOKEN},
    '{'{".", 1'b0}, 1'b0, NO_TOKEN},
    '{'{"_", 1'b0}, 1'b0, NO_TOKEN},
    '{'{".", 1'b0}, 1'b0, NO_TOKEN},
    '{'{"5", 1'b1}, 1'b0, NO_TOKEN},
    // Top code unit as a one-character text: unhandled, and no end token.
    '{'{16'hFFFF, 1'b1}, 1'b1,
      '{KIND_ERROR, 31'd0, 16'd0, 16'd0, ERR_UNHANDLED, 16'hFFFF, 1'b1}},
    // Number cut off by code unit zero; the tail of the text is discarded.
    '{'{"4", 1'b0}, 1'b0, NO_TOKEN},
    '{'{16'h0000, 1'b0}, 1'b0, NO_TOKEN},
    '{'{"a", 1'b1}, 1'b0, NO_TOKEN},
    // Text that ends right after a colon.
    '{'{":", 1'b1}, 1'b1, '{KIND_ERROR, 31'd0, 16'd0, 16'd0, ERR_END_COLON, 16'd0, 1'b1}},
    // Colon followed by a letter.
    '{'{":", 1'b0}, 1'b0, NO_TOKEN},
    '{'{"x", 1'b0}, 1'b1, '{KIND_ERROR, 31'd0, 16'd0, 16'd0, ERR_BAD_COLON, 16'h0078, 1'b1}},
    '{'{" ", 1'b1}, 1'b0, NO_TOKEN},
    // Bang as the last character, then a text of only whitespace.
    '{'{"!", 1'b1}, 1'b0, NO_TOKEN},
    '{'{" ", 1'b1}, 1'b1, '{KIND_END, 31'd0, 16'd0, 16'd0, ERR_NONE, 16'd0, 1'b1}}
  };

  // --------------------------------------------------------------------------
  // Receiver. out_stall is redrawn every cycle from recv_stall_pct. When the
  // sender raises hold_out, the receiver keeps out_stall high for a long
  // stretch so the result queue fills and the block has to stall its input.
  // --------------------------------------------------------------------------
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_out) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out = 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Token checker. Every output transfer is compared with the oldest token
  // still owed; a transfer with nothing owed is itself a failure.
  // --------------------------------------------------------------------------
  int       fail_count = 0;
  stl_out_t want;

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] got_val);
    if (exp_val !== got_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (token_q.size() == 0) begin
        $error("token with nothing owed: kind %0d", out_data.token_kind);
        fail_count++;
      end else begin
        want = token_q.pop_front();
        check_field("token_kind",   want.token_kind,   out_data.token_kind);
        check_field("number_value", want.number_value, out_data.number_value);
        check_field("ident_start",  want.ident_start,  out_data.ident_start);
        check_field("ident_length", want.ident_length, out_data.ident_length);
        check_field("error_code",   want.error_code,   out_data.error_code);
        check_field("error_char",   want.error_char,   out_data.error_char);
        check_field("run_last",     want.run_last,     out_data.run_last);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: counts cycles in which neither channel completes a transfer.
  // --------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("FAIL signature_token_lexer_unit");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    send_gap_pct   = 24;
    recv_stall_pct = 78;
    clear_lexer();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Phase one: mostly ready sender, slow receiver. Directed rows first, then
    // random texts with one long receiver hold-off in the middle.
    foreach (dir_rows[r])
      send_char(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].tok);
    random_texts(145, 1'b1);
    wait_drained();

    // Phase two: slow sender, mostly ready receiver.
    send_gap_pct   = 78;
    recv_stall_pct = 24;
    random_texts(145, 1'b0);
    wait_drained();

    // Phase three: back to back on both sides.
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    random_texts(145, 1'b0);

    wait_drained();
    repeat (DRAIN_TAIL) @(posedge clk);

    if (fail_count == 0)
      $display("PASS signature_token_lexer_unit");
    else
      $display("FAIL signature_token_lexer_unit");
    $finish;
  end

endmodule
